/* rtl/assert_macros.svh */
// assertion macros used by the rtl controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TMSG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define TMSG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/tmsg_pkg.sv */
`timescale 1ns / 1ps

package tmsg_pkg;

  localparam int LAT_W     = 31;
  localparam int LON_W     = 32;
  localparam int HGT_W     = 32;
  localparam int CNT_W     = 9;
  localparam int CFG_W     = 9;
  localparam int COORD_W   = 8;
  localparam int CFG_IDX_W = 1;

  // shared multiplier operand widths
  localparam int MUL_AW = 68;
  localparam int MUL_BW = 34;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int NUM_W  = 104;
  localparam int DIV_NW = 106;
  localparam int DIV_DW = MUL_AW;
  localparam int CMP_W  = 80;
  localparam int SUM_W  = 108;
  localparam int EDGE_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b1;

  localparam logic [CNT_W-1:0]        CNT_MAX = 9'd511;
  localparam logic signed [HGT_W-1:0] HGT_MIN = 32'sh8000_0000;
  localparam logic signed [HGT_W-1:0] HGT_MAX = 32'sh7fff_ffff;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_READ  = 2'd1,
    OP_SPLAT = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [4:0] {
    DP_NONE, DP_CAPTURE, DP_LOAD, DP_READ, DP_READ_TAKE, DP_SETUP,
    DP_MUL_GO, DP_MUL_TAKE, DP_DET_FIX, DP_CELL_READ, DP_CELL_BOX,
    DP_FLIP, DP_DIV_GO, DP_QUOT, DP_SAT, DP_NEXT, DP_POST
  } dp_op_t;

  typedef enum logic [2:0] {
    JOB_DET0, JOB_DET1, JOB_NA0, JOB_NA1, JOB_NB0, JOB_NB1, JOB_NUM0, JOB_NUM1
  } mul_job_t;

  typedef struct packed {
    dp_op_t   op;
    mul_job_t job;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic det_zero;
    logic grid_empty;
    logic in_box;
    logic pass;
    logic last_cell;
    logic mul_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/tmsg_mul.sv */
`timescale 1ns / 1ps

module tmsg_mul #(
  parameter int AW = 68,
  parameter int BW = 34
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic signed [BW-1:0]     b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  p
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0]    a_r;
  logic [BW-1:0]           b_r;
  logic signed [AW+BW-1:0] acc_r;
  logic signed [AW+BW-1:0] term;
  logic signed [AW+BW-1:0] acc_nxt;
  logic [CW-1:0]           cnt_r;
  logic                    busy_r;
  logic                    done_r;

  // msb first, sign bit carries negative weight
  always_comb begin
    if (!b_r[BW-1]) begin
      term = '0;
    end else if (cnt_r == CW'(BW)) begin
      term = -((AW+BW)'(a_r));
    end else begin
      term = (AW+BW)'(a_r);
    end
    acc_nxt = (acc_r <<< 1) + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(BW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[BW-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

/* rtl/tmsg_div.sv */
`timescale 1ns / 1ps

module tmsg_div #(
  parameter int NW = 106,
  parameter int DW = 68
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic          done,
  output logic [NW-1:0] q,
  output logic          rem_nz
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n_r;
  logic [NW-1:0] q_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic          ge;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  // restoring, one quotient bit a cycle
  always_comb begin
    trial = {rem_r, n_r[NW-1]};
    ge    = trial >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= n;
      d_r   <= d;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      n_r   <= {n_r[NW-2:0], 1'b0};
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= ge ? DW'(trial - {1'b0, d_r}) : DW'(trial);
    end
  end

  assign done   = done_r;
  assign q      = q_r;
  assign rem_nz = rem_r != '0;

endmodule

/* rtl/tmsg_dp.sv */
`timescale 1ns / 1ps

module tmsg_dp #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256,
  parameter int WINDOW   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tmsg_pkg::dp_cmd_t                      cmd,
  output tmsg_pkg::dp_status_t                   status,
  input  logic                                   cfg_valid,
  input  logic [tmsg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tmsg_pkg::CFG_W-1:0]             cfg_data,
  input  logic [1:0]                             in_operation,
  input  logic [tmsg_pkg::COORD_W-1:0]           in_col,
  input  logic [tmsg_pkg::COORD_W-1:0]           in_row,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v0,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v1,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v2,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v0,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v1,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v2,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v0,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v1,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v2,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tmsg_pkg::HGT_W-1:0]      out_read_height,
  output logic [tmsg_pkg::CNT_W-1:0]             out_cells_raised
);

  import tmsg_pkg::*;

  localparam int XW    = $clog2(MAX_COLS);
  localparam int YW    = $clog2(MAX_ROWS);
  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  function automatic logic signed [EDGE_W-1:0] clamp_edge(
    input logic signed [EDGE_W-1:0] v,
    input logic signed [EDGE_W-1:0] last
  );
    logic signed [EDGE_W-1:0] r;
    r = v;
    if (r < 0) r = '0;
    if (r > last) r = last;
    return r;
  endfunction

  // cell store
  logic signed [LAT_W-1:0] mem_lat [DEPTH];
  logic signed [LON_W-1:0] mem_lon [DEPTH];
  logic signed [HGT_W-1:0] mem_hgt [DEPTH];

  logic signed [LAT_W-1:0] rd_lat_r;
  logic signed [LON_W-1:0] rd_lon_r;
  logic signed [HGT_W-1:0] rd_hgt_r;

  // item
  op_t                     op_r;
  logic [COORD_W-1:0]      col_r, row_r;
  logic                    inside_r;
  logic [AW-1:0]           item_addr_r;
  logic signed [LAT_W-1:0] lat0_r, lat1_r, lat2_r;
  logic signed [LON_W-1:0] lon0_r, lon1_r, lon2_r;
  logic signed [HGT_W-1:0] h0_r, h1_r, h2_r;

  // triangle
  logic signed [MUL_BW-1:0] a00_r, a01_r, a10_r, a11_r, dh1_r, dh2_r;
  logic signed [LAT_W-1:0]  minlat_r, maxlat_r;
  logic signed [LON_W-1:0]  minlon_r, maxlon_r;
  logic signed [MUL_AW-1:0] det_r;
  logic                     flip_r;
  logic                     empty_r;

  // scan
  logic [XW-1:0] ix_r, x0_r, x1_r;
  logic [YW-1:0] iy_r, y0_r, y1_r;
  logic [AW-1:0] scan_addr;

  // per cell
  logic signed [MUL_BW-1:0] b0_r, b1_r;
  logic signed [MUL_AW-1:0] na_r, nb_r;
  logic signed [NUM_W-1:0]  num_r;
  logic                     n_neg_r;
  logic signed [SUM_W-1:0]  tot_r;

  // results
  logic signed [HGT_W-1:0] res_height_r;
  logic [CNT_W-1:0]        count_r;
  logic                    out_valid_r;
  logic signed [HGT_W-1:0] out_height_r;
  logic [CNT_W-1:0]        out_count_r;

  logic [CFG_W-1:0] cols_r, rows_r;

  // arithmetic units
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  logic                     mul_done;
  logic [DIV_NW-1:0]        div_n;
  logic [DIV_DW-1:0]        div_d;
  logic [DIV_NW-1:0]        div_q;
  logic                     div_rnz;
  logic                     div_done;
  logic signed [DIV_NW-1:0] n_full;

  logic                     mem_rd;
  logic [AW-1:0]            rd_addr;
  logic                     raise;
  logic signed [HGT_W-1:0]  sat_v;
  logic                     in_box;
  logic                     pass;
  logic signed [CMP_W-1:0]  na_c, nb_c, det_c, na_k, nb_k, det_k, sum_k;
  logic signed [SUM_W-1:0]  q_ext, q_s;

  logic signed [EDGE_W-1:0] nc_e, nr_e, cx_e, cy_e, win_e;
  logic signed [LAT_W-1:0]  minlat_c, maxlat_c;
  logic signed [LON_W-1:0]  minlon_c, maxlon_c;

  assign scan_addr = AW'(32'(ix_r) + 32'(iy_r) * 32'(MAX_COLS));

  always_comb begin
    unique case (cmd.job)
      JOB_DET0: begin mul_a = MUL_AW'(a00_r); mul_b = a11_r; end
      JOB_DET1: begin mul_a = MUL_AW'(a01_r); mul_b = a10_r; end
      JOB_NA0:  begin mul_a = MUL_AW'(a11_r); mul_b = b0_r;  end
      JOB_NA1:  begin mul_a = MUL_AW'(a01_r); mul_b = b1_r;  end
      JOB_NB0:  begin mul_a = MUL_AW'(a00_r); mul_b = b1_r;  end
      JOB_NB1:  begin mul_a = MUL_AW'(a10_r); mul_b = b0_r;  end
      JOB_NUM0: begin mul_a = na_r;           mul_b = dh1_r; end
      JOB_NUM1: begin mul_a = nb_r;           mul_b = dh2_r; end
      default:  begin mul_a = '0;             mul_b = '0;    end
    endcase
  end

  tmsg_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == DP_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (prod)
  );

  always_comb begin
    n_full = (DIV_NW'(num_r) <<< 1) + DIV_NW'(det_r);
    div_n  = n_full[DIV_NW-1] ? DIV_NW'(-n_full) : DIV_NW'(n_full);
    div_d  = {det_r[DIV_DW-2:0], 1'b0};
  end

  tmsg_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.op == DP_DIV_GO),
    .n      (div_n),
    .d      (div_d),
    .done   (div_done),
    .q      (div_q),
    .rem_nz (div_rnz)
  );

  // barycentric bounds, scaled by 1000
  always_comb begin
    na_c  = CMP_W'(na_r);
    nb_c  = CMP_W'(nb_r);
    det_c = CMP_W'(det_r);
    na_k  = (na_c <<< 10) - (na_c <<< 4) - (na_c <<< 3);
    nb_k  = (nb_c <<< 10) - (nb_c <<< 4) - (nb_c <<< 3);
    det_k = (det_c <<< 10) - (det_c <<< 4) - (det_c <<< 3) + det_c;
    sum_k = na_k + nb_k;
    pass  = (na_k >= -det_c) && (nb_k >= -det_c) && (det_k >= sum_k);
  end

  assign in_box = (rd_lat_r >= minlat_r) && (rd_lat_r <= maxlat_r) &&
                  (rd_lon_r >= minlon_r) && (rd_lon_r <= maxlon_r);

  always_comb begin
    q_ext = $signed(SUM_W'(div_q));
    q_s   = n_neg_r ? -(q_ext + $signed(SUM_W'(div_rnz))) : q_ext;
  end

  always_comb begin
    if (tot_r < SUM_W'(HGT_MIN)) begin
      sat_v = HGT_MIN;
    end else if (tot_r > SUM_W'(HGT_MAX)) begin
      sat_v = HGT_MAX;
    end else begin
      sat_v = tot_r[HGT_W-1:0];
    end
    raise = (cmd.op == DP_SAT) && (sat_v > rd_hgt_r);
  end

  always_comb begin
    nc_e  = (32'(cols_r) > MAX_COLS) ? EDGE_W'(MAX_COLS) : $signed(EDGE_W'(cols_r));
    nr_e  = (32'(rows_r) > MAX_ROWS) ? EDGE_W'(MAX_ROWS) : $signed(EDGE_W'(rows_r));
    cx_e  = $signed(EDGE_W'(col_r));
    cy_e  = $signed(EDGE_W'(row_r));
    win_e = EDGE_W'(WINDOW);
    minlat_c = (lat0_r < lat1_r) ? lat0_r : lat1_r;
    if (lat2_r < minlat_c) minlat_c = lat2_r;
    maxlat_c = (lat0_r > lat1_r) ? lat0_r : lat1_r;
    if (lat2_r > maxlat_c) maxlat_c = lat2_r;
    minlon_c = (lon0_r < lon1_r) ? lon0_r : lon1_r;
    if (lon2_r < minlon_c) minlon_c = lon2_r;
    maxlon_c = (lon0_r > lon1_r) ? lon0_r : lon1_r;
    if (lon2_r > maxlon_c) maxlon_c = lon2_r;
  end

  // memory ports
  assign mem_rd  = (cmd.op == DP_READ) || (cmd.op == DP_CELL_READ);
  assign rd_addr = (cmd.op == DP_READ) ? item_addr_r : scan_addr;

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_lat_r <= mem_lat[rd_addr];
      rd_lon_r <= mem_lon[rd_addr];
      rd_hgt_r <= mem_hgt[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_LOAD && inside_r) begin
      mem_lat[item_addr_r] <= lat0_r;
      mem_lon[item_addr_r] <= lon0_r;
      mem_hgt[item_addr_r] <= h0_r;
    end else if (raise) begin
      mem_hgt[scan_addr] <= sat_v;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r      <= CFG_W'(256);
      rows_r      <= CFG_W'(256);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_COLS) begin
          cols_r <= cfg_data;
        end else begin
          rows_r <= cfg_data;
        end
      end
      if (cmd.op == DP_POST) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DP_CAPTURE: begin
        op_r         <= op_t'(in_operation);
        col_r        <= in_col;
        row_r        <= in_row;
        inside_r     <= (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);
        item_addr_r  <= AW'(32'(in_col) + 32'(in_row) * 32'(MAX_COLS));
        lat0_r       <= in_lat_v0;
        lat1_r       <= in_lat_v1;
        lat2_r       <= in_lat_v2;
        lon0_r       <= in_lon_v0;
        lon1_r       <= in_lon_v1;
        lon2_r       <= in_lon_v2;
        h0_r         <= in_height_v0;
        h1_r         <= in_height_v1;
        h2_r         <= in_height_v2;
        res_height_r <= '0;
        count_r      <= '0;
      end
      DP_READ_TAKE: begin
        res_height_r <= inside_r ? rd_hgt_r : '0;
      end
      DP_SETUP: begin
        a00_r    <= MUL_BW'(lat1_r) - MUL_BW'(lat0_r);
        a01_r    <= MUL_BW'(lat2_r) - MUL_BW'(lat0_r);
        a10_r    <= MUL_BW'(lon1_r) - MUL_BW'(lon0_r);
        a11_r    <= MUL_BW'(lon2_r) - MUL_BW'(lon0_r);
        dh1_r    <= MUL_BW'(h1_r) - MUL_BW'(h0_r);
        dh2_r    <= MUL_BW'(h2_r) - MUL_BW'(h0_r);
        minlat_r <= minlat_c;
        maxlat_r <= maxlat_c;
        minlon_r <= minlon_c;
        maxlon_r <= maxlon_c;
        empty_r  <= (nc_e == 0) || (nr_e == 0);
        x0_r     <= XW'(clamp_edge(cx_e - win_e, nc_e - EDGE_W'(1)));
        x1_r     <= XW'(clamp_edge(cx_e + win_e, nc_e - EDGE_W'(1)));
        y0_r     <= YW'(clamp_edge(cy_e - win_e, nr_e - EDGE_W'(1)));
        y1_r     <= YW'(clamp_edge(cy_e + win_e, nr_e - EDGE_W'(1)));
        ix_r     <= XW'(clamp_edge(cx_e - win_e, nc_e - EDGE_W'(1)));
        iy_r     <= YW'(clamp_edge(cy_e - win_e, nr_e - EDGE_W'(1)));
        flip_r   <= 1'b0;
        count_r  <= '0;
      end
      DP_MUL_TAKE: begin
        if (mul_done) begin
          unique case (cmd.job)
            JOB_DET0: det_r <= MUL_AW'(prod);
            JOB_DET1: det_r <= det_r - MUL_AW'(prod);
            JOB_NA0:  na_r  <= MUL_AW'(prod);
            JOB_NA1:  na_r  <= na_r - MUL_AW'(prod);
            JOB_NB0:  nb_r  <= MUL_AW'(prod);
            JOB_NB1:  nb_r  <= nb_r - MUL_AW'(prod);
            JOB_NUM0: num_r <= NUM_W'(prod);
            JOB_NUM1: num_r <= num_r + NUM_W'(prod);
            default: ;
          endcase
        end
      end
      DP_DET_FIX: begin
        if (det_r < 0) begin
          det_r  <= -det_r;
          flip_r <= 1'b1;
        end
      end
      DP_CELL_BOX: begin
        b0_r <= MUL_BW'(rd_lat_r) - MUL_BW'(lat0_r);
        b1_r <= MUL_BW'(rd_lon_r) - MUL_BW'(lon0_r);
      end
      DP_FLIP: begin
        if (flip_r) begin
          na_r <= -na_r;
          nb_r <= -nb_r;
        end
      end
      DP_DIV_GO: begin
        n_neg_r <= n_full[DIV_NW-1];
      end
      DP_QUOT: begin
        tot_r <= q_s + SUM_W'(h0_r);
      end
      DP_SAT: begin
        if (raise && count_r != CNT_MAX) begin
          count_r <= count_r + 1'b1;
        end
      end
      DP_NEXT: begin
        if (!((ix_r == x1_r) && (iy_r == y1_r))) begin
          if (iy_r == y1_r) begin
            iy_r <= y0_r;
            ix_r <= ix_r + 1'b1;
          end else begin
            iy_r <= iy_r + 1'b1;
          end
        end
      end
      DP_POST: begin
        out_height_r <= res_height_r;
        out_count_r  <= count_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.op         = op_r;
    status.det_zero   = det_r == '0;
    status.grid_empty = empty_r;
    status.in_box     = in_box;
    status.pass       = pass;
    status.last_cell  = (ix_r == x1_r) && (iy_r == y1_r);
    status.mul_done   = mul_done;
    status.div_done   = div_done;
    status.out_free   = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_read_height  = out_height_r;
  assign out_cells_raised = out_count_r;

endmodule

/* rtl/tmsg_ctrl.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tmsg_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output tmsg_pkg::dp_cmd_t    cmd,
  input  tmsg_pkg::dp_status_t status
);

  import tmsg_pkg::*;

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DISPATCH = 19'h00002,
    S_LOAD     = 19'h00004,
    S_READ     = 19'h00008,
    S_RDTAKE   = 19'h00010,
    S_SETUP    = 19'h00020,
    S_MGO      = 19'h00040,
    S_MWAIT    = 19'h00080,
    S_DETCHK   = 19'h00100,
    S_CRD      = 19'h00200,
    S_CBOX     = 19'h00400,
    S_FLIP     = 19'h00800,
    S_TEST     = 19'h01000,
    S_DIVGO    = 19'h02000,
    S_DIVW     = 19'h04000,
    S_QUOT     = 19'h08000,
    S_SAT      = 19'h10000,
    S_NEXT     = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  state_t   state_r, state_nxt;
  mul_job_t job_r, job_nxt;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    cmd.op    = DP_NONE;
    cmd.job   = job_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_LOAD:  state_nxt = S_LOAD;
          OP_READ:  state_nxt = S_READ;
          OP_SPLAT: state_nxt = S_SETUP;
          OP_NOP:   state_nxt = S_DONE;
          default:  state_nxt = S_DONE;
        endcase
      end
      S_LOAD: begin
        cmd.op    = DP_LOAD;
        state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.op    = DP_READ;
        state_nxt = S_RDTAKE;
      end
      S_RDTAKE: begin
        cmd.op    = DP_READ_TAKE;
        state_nxt = S_DONE;
      end
      S_SETUP: begin
        cmd.op    = DP_SETUP;
        job_nxt   = JOB_DET0;
        state_nxt = S_MGO;
      end
      S_MGO: begin
        cmd.op    = DP_MUL_GO;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        cmd.op = DP_MUL_TAKE;
        if (status.mul_done) begin
          unique case (job_r)
            JOB_DET0: begin job_nxt = JOB_DET1; state_nxt = S_MGO;    end
            JOB_DET1: begin                     state_nxt = S_DETCHK; end
            JOB_NA0:  begin job_nxt = JOB_NA1;  state_nxt = S_MGO;    end
            JOB_NA1:  begin job_nxt = JOB_NB0;  state_nxt = S_MGO;    end
            JOB_NB0:  begin job_nxt = JOB_NB1;  state_nxt = S_MGO;    end
            JOB_NB1:  begin                     state_nxt = S_FLIP;   end
            JOB_NUM0: begin job_nxt = JOB_NUM1; state_nxt = S_MGO;    end
            JOB_NUM1: begin                     state_nxt = S_DIVGO;  end
            default:  begin                     state_nxt = S_DONE;   end
          endcase
        end
      end
      S_DETCHK: begin
        cmd.op    = DP_DET_FIX;
        state_nxt = (status.det_zero || status.grid_empty) ? S_DONE : S_CRD;
      end
      S_CRD: begin
        cmd.op    = DP_CELL_READ;
        state_nxt = S_CBOX;
      end
      S_CBOX: begin
        cmd.op = DP_CELL_BOX;
        if (status.in_box) begin
          job_nxt   = JOB_NA0;
          state_nxt = S_MGO;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_FLIP: begin
        cmd.op    = DP_FLIP;
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (status.pass) begin
          job_nxt   = JOB_NUM0;
          state_nxt = S_MGO;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIVGO: begin
        cmd.op    = DP_DIV_GO;
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (status.div_done) begin
          state_nxt = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd.op    = DP_QUOT;
        state_nxt = S_SAT;
      end
      S_SAT: begin
        cmd.op    = DP_SAT;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.op    = DP_NEXT;
        state_nxt = status.last_cell ? S_DONE : S_CRD;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op    = DP_POST;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      job_r   <= JOB_DET0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
    end
  end

  assign in_stall = state_r != S_IDLE;

  `TMSG_ASSERT_NXT(a_accept_dispatch, clk, rst_n, in_valid && !in_stall, state_r == S_DISPATCH)
  `TMSG_ASSERT_IMP(a_mul_done_waited, clk, rst_n, status.mul_done, state_r == S_MWAIT)
  `TMSG_ASSERT_IMP(a_div_done_waited, clk, rst_n, status.div_done, state_r == S_DIVW)

endmodule

/* rtl/triangle_max_splat_to_grid.sv */
`timescale 1ns / 1ps

// Max-blend triangle splat onto a grid of MAX_COLS x MAX_ROWS cells held in
// on-chip memory (latitude, longitude, height per cell). One transaction in
// gives one transaction out. A splat first forms two determinant products on
// the shared 34-step shift-add multiplier, then visits each window cell: one
// outside the triangle's bounding box is skipped, one in the box that fails
// the barycentric test costs four products, and one that passes costs six
// products and a pass through the 106-step restoring divider.
// Cells never loaded read as undefined, so load every cell before use.
module triangle_max_splat_to_grid #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256,
  parameter int WINDOW   = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tmsg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tmsg_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_operation,
  input  logic [tmsg_pkg::COORD_W-1:0]           in_col,
  input  logic [tmsg_pkg::COORD_W-1:0]           in_row,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v0,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v1,
  input  logic signed [tmsg_pkg::LAT_W-1:0]      in_lat_v2,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v0,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v1,
  input  logic signed [tmsg_pkg::LON_W-1:0]      in_lon_v2,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v0,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v1,
  input  logic signed [tmsg_pkg::HGT_W-1:0]      in_height_v2,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tmsg_pkg::HGT_W-1:0]      out_read_height,
  output logic [tmsg_pkg::CNT_W-1:0]             out_cells_raised
);

  import tmsg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  tmsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  tmsg_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .WINDOW   (WINDOW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_operation     (in_operation),
    .in_col           (in_col),
    .in_row           (in_row),
    .in_lat_v0        (in_lat_v0),
    .in_lat_v1        (in_lat_v1),
    .in_lat_v2        (in_lat_v2),
    .in_lon_v0        (in_lon_v0),
    .in_lon_v1        (in_lon_v1),
    .in_lon_v2        (in_lon_v2),
    .in_height_v0     (in_height_v0),
    .in_height_v1     (in_height_v1),
    .in_height_v2     (in_height_v2),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_height  (out_read_height),
    .out_cells_raised (out_cells_raised)
  );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tmsg_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    op_t                op;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [30:0] lat [3];
    logic signed [31:0] lon [3];
    logic signed [31:0] hgt [3];
  } grid_item_t;

  typedef struct {
    logic signed [31:0] read_height;
    logic [8:0]         cells_raised;
  } grid_result_t;

  localparam int GRID_COLS = 256;
  localparam int GRID_ROWS = 256;
  localparam int RADIUS    = 10;
  localparam wide_t HEIGHT_LO = -128'sd2147483648;
  localparam wide_t HEIGHT_HI = 128'sd2147483647;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [COORD_W-1:0] in_col = '0;
  logic [COORD_W-1:0] in_row = '0;
  logic signed [LAT_W-1:0] in_lat_v0 = '0, in_lat_v1 = '0, in_lat_v2 = '0;
  logic signed [LON_W-1:0] in_lon_v0 = '0, in_lon_v1 = '0, in_lon_v2 = '0;
  logic signed [HGT_W-1:0] in_height_v0 = '0, in_height_v1 = '0, in_height_v2 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [HGT_W-1:0] out_read_height;
  logic [CNT_W-1:0] out_cells_raised;

  triangle_max_splat_to_grid dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_operation(in_operation),
    .in_col(in_col), .in_row(in_row),
    .in_lat_v0(in_lat_v0), .in_lat_v1(in_lat_v1), .in_lat_v2(in_lat_v2),
    .in_lon_v0(in_lon_v0), .in_lon_v1(in_lon_v1), .in_lon_v2(in_lon_v2),
    .in_height_v0(in_height_v0), .in_height_v1(in_height_v1), .in_height_v2(in_height_v2),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_read_height(out_read_height), .out_cells_raised(out_cells_raised)
  );

  int cell_lat_m [GRID_COLS*GRID_ROWS];
  int cell_lon_m [GRID_COLS*GRID_ROWS];
  int cell_hgt_m [GRID_COLS*GRID_ROWS];
  bit cell_loaded [GRID_COLS*GRID_ROWS];
  logic [8:0] cols_reg = 9'd256;
  logic [8:0] rows_reg = 9'd256;

  grid_result_t pending_q [$];
  grid_result_t head;
  int mismatches = 0;
  int hold_request = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #240000000;
    $display("tb: errors");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transaction", out_cells_raised, 0);
      end else begin
        head = pending_q.pop_front();
        if (out_read_height !== head.read_height)
          report_mismatch("read_height", out_read_height, head.read_height);
        if (out_cells_raised !== head.cells_raised)
          report_mismatch("cells_raised", out_cells_raised, head.cells_raised);
      end
    end
  end

  // receiver: random stalls, plus long hold-off on request
  int stall_left = 0;
  int free_left = 0;
  int pick;
  always @(posedge clk) begin
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (free_left > 0) begin
      out_stall <= 1'b0;
      free_left--;
    end else begin
      out_stall <= 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 50) free_left = $urandom_range(0, 4);
      else if (pick < 80) stall_left = $urandom_range(1, 3);
      else if (pick < 90) stall_left = $urandom_range(15, 60);
      else free_left = $urandom_range(50, 200);
    end
  end

  function automatic int clamp_to(int v, int last);
    if (v < 0) v = 0;
    if (v > last) v = last;
    return v;
  endfunction

  function automatic int used_cols();
    return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
  endfunction

  function automatic int used_rows();
    return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
  endfunction

  function automatic logic [8:0] splat_raise(grid_item_t t);
    wide_t l0, l1, l2, o0, o1, o2, h0, h1, h2;
    wide_t a00, a01, a10, a11, det, mdet, na, nb, num, n2, d2, q, tot, clat, clon;
    wide_t mnla, mxla, mnlo, mxlo;
    int nc, nr, cx, cy, x0, x1, y0, y1, a;
    logic [8:0] cnt;
    logic flip;
    l0 = t.lat[0]; l1 = t.lat[1]; l2 = t.lat[2];
    o0 = t.lon[0]; o1 = t.lon[1]; o2 = t.lon[2];
    h0 = t.hgt[0]; h1 = t.hgt[1]; h2 = t.hgt[2];
    nc = used_cols();
    nr = used_rows();
    if (nc == 0 || nr == 0) return 9'd0;
    a00 = l1 - l0; a01 = l2 - l0; a10 = o1 - o0; a11 = o2 - o0;
    det = a00 * a11 - a01 * a10;
    if (det == 0) return 9'd0;
    flip = det < 0;
    if (flip) det = -det;
    mdet = -det;
    mnla = l0; if (l1 < mnla) mnla = l1; if (l2 < mnla) mnla = l2;
    mxla = l0; if (l1 > mxla) mxla = l1; if (l2 > mxla) mxla = l2;
    mnlo = o0; if (o1 < mnlo) mnlo = o1; if (o2 < mnlo) mnlo = o2;
    mxlo = o0; if (o1 > mxlo) mxlo = o1; if (o2 > mxlo) mxlo = o2;
    cx = t.col;
    cy = t.row;
    x0 = clamp_to(cx - RADIUS, nc - 1); x1 = clamp_to(cx + RADIUS, nc - 1);
    y0 = clamp_to(cy - RADIUS, nr - 1); y1 = clamp_to(cy + RADIUS, nr - 1);
    cnt = 9'd0;
    for (int ix = x0; ix <= x1; ix++) begin
      for (int iy = y0; iy <= y1; iy++) begin
        a = ix + GRID_COLS * iy;
        clat = cell_lat_m[a];
        clon = cell_lon_m[a];
        if (clat < mnla || clat > mxla || clon < mnlo || clon > mxlo) continue;
        na = a11 * (clat - l0) - a01 * (clon - o0);
        nb = a00 * (clon - o0) - a10 * (clat - l0);
        if (flip) begin
          na = -na;
          nb = -nb;
        end
        if (na * 1000 < mdet || nb * 1000 < mdet) continue;
        if (det * 1001 < (na + nb) * 1000) continue;
        num = na * (h1 - h0) + nb * (h2 - h0);
        n2 = 2 * num + det;
        d2 = 2 * det;
        q = n2 / d2;
        if (n2 < 0 && n2 % d2 != 0) q = q - 1;
        tot = q + h0;
        if (tot < HEIGHT_LO) tot = HEIGHT_LO;
        if (tot > HEIGHT_HI) tot = HEIGHT_HI;
        if ($signed(tot[31:0]) > cell_hgt_m[a]) begin
          cell_hgt_m[a] = tot[31:0];
          if (cnt != CNT_MAX) cnt++;
        end
      end
    end
    return cnt;
  endfunction

  function automatic grid_result_t apply_item(grid_item_t t);
    grid_result_t r;
    int a;
    r.read_height = '0;
    r.cells_raised = '0;
    a = t.col + GRID_COLS * t.row;
    case (t.op)
      OP_LOAD: begin
        cell_lat_m[a] = t.lat[0];
        cell_lon_m[a] = t.lon[0];
        cell_hgt_m[a] = t.hgt[0];
        cell_loaded[a] = 1'b1;
      end
      OP_READ: r.read_height = cell_hgt_m[a];
      OP_SPLAT: r.cells_raised = splat_raise(t);
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit window_loaded(int cx, int cy);
    int nc, nr;
    nc = used_cols();
    nr = used_rows();
    if (nc == 0 || nr == 0) return 1'b1;
    for (int ix = clamp_to(cx - RADIUS, nc - 1); ix <= clamp_to(cx + RADIUS, nc - 1); ix++)
      for (int iy = clamp_to(cy - RADIUS, nr - 1); iy <= clamp_to(cy + RADIUS, nr - 1); iy++)
        if (!cell_loaded[ix + GRID_COLS * iy]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int near_edge();
    return $urandom_range(0, 1) ? $urandom_range(0, 31) : $urandom_range(224, 255);
  endfunction

  function automatic grid_item_t blank_item(op_t op, int col, int row);
    grid_item_t t;
    t.op = op;
    t.col = 8'(col);
    t.row = 8'(row);
    for (int i = 0; i < 3; i++) begin
      t.lat[i] = 31'($urandom);
      t.lon[i] = $urandom;
      t.hgt[i] = $urandom;
    end
    return t;
  endfunction

  function automatic grid_item_t load_item(int c, int r);
    grid_item_t t;
    t = blank_item(OP_LOAD, c, r);
    t.lat[0] = 31'(r * 1000 + int'($urandom_range(0, 99)));
    t.lon[0] = c * 1000 + int'($urandom_range(0, 99));
    if ($urandom_range(0, 9) != 0) t.hgt[0] = int'($urandom_range(0, 10000)) - 5000;
    return t;
  endfunction

  function automatic grid_item_t tri_item(int cx, int cy, int la0, int lo0, int h0,
                                          int la1, int lo1, int h1,
                                          int la2, int lo2, int h2);
    grid_item_t t;
    t = blank_item(OP_SPLAT, cx, cy);
    t.lat[0] = 31'(la0); t.lon[0] = lo0; t.hgt[0] = h0;
    t.lat[1] = 31'(la1); t.lon[1] = lo1; t.hgt[1] = h1;
    t.lat[2] = 31'(la2); t.lon[2] = lo2; t.hgt[2] = h2;
    return t;
  endfunction

  function automatic void safe_centre(output int cx, output int cy);
    for (int k = 0; k < 300; k++) begin
      cx = near_edge();
      cy = near_edge();
      if (window_loaded(cx, cy)) return;
    end
    cx = 5;
    cy = 5;
  endfunction

  function automatic grid_item_t small_splat();
    grid_item_t t;
    int cx, cy;
    safe_centre(cx, cy);
    t = blank_item(OP_SPLAT, cx, cy);
    for (int i = 0; i < 3; i++) begin
      t.lat[i] = 31'(cy * 1000 + int'($urandom_range(0, 6000)) - 3000);
      t.lon[i] = cx * 1000 + int'($urandom_range(0, 6000)) - 3000;
      if ($urandom_range(0, 9) < 7) t.hgt[i] = int'($urandom_range(0, 23000)) - 3000;
    end
    if ($urandom_range(0, 19) == 0) begin
      t.lat[2] = t.lat[1];
      t.lon[2] = t.lon[1];
    end
    return t;
  endfunction

  function automatic grid_item_t noise_splat();
    grid_item_t t;
    int cx, cy, v;
    bit neg_lat, neg_lon;
    safe_centre(cx, cy);
    t = blank_item(OP_SPLAT, cx, cy);
    neg_lat = $urandom_range(0, 1);
    neg_lon = $urandom_range(0, 1);
    for (int i = 0; i < 3; i++) begin
      v = $urandom_range(1000000, 900000000);
      t.lat[i] = 31'(neg_lat ? -v : v);
      v = $urandom_range(1000000, 1800000000);
      t.lon[i] = neg_lon ? -v : v;
    end
    return t;
  endfunction

  task automatic send_item(grid_item_t t, bit eager);
    int gap;
    gap = eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_operation <= t.op;
    in_col <= t.col;
    in_row <= t.row;
    in_lat_v0 <= t.lat[0]; in_lat_v1 <= t.lat[1]; in_lat_v2 <= t.lat[2];
    in_lon_v0 <= t.lon[0]; in_lon_v1 <= t.lon[1]; in_lon_v2 <= t.lon[2];
    in_height_v0 <= t.hgt[0]; in_height_v1 <= t.hgt[1]; in_height_v2 <= t.hgt[2];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_q.push_back(apply_item(t));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_COLS) cols_reg = val;
    else rows_reg = val;
  endtask

  task automatic set_grid_size(logic [8:0] c, logic [8:0] r);
    write_reg(REG_COLS, c);
    write_reg(REG_ROWS, r);
  endtask

  task automatic test_fill_grid();
    grid_item_t t;
    for (int r = 0; r < 32; r++)
      for (int c = 0; c < 32; c++) send_item(load_item(c, r), 1'b0);
    for (int r = 232; r < 256; r++)
      for (int c = 232; c < 256; c++) send_item(load_item(c, r), 1'b0);
    t = load_item(0, 0);
    t.lat[0] = -31'sd900000000; t.lon[0] = -1800000000; t.hgt[0] = HGT_MIN;
    send_item(t, 1'b0);
    t = load_item(255, 0);
    t.lat[0] = 31'sd900000000; t.lon[0] = 1800000000; t.hgt[0] = HGT_MAX;
    send_item(t, 1'b0);
  endtask

  task automatic test_special_cases();
    int a, b, c;
    set_grid_size(9'd256, 9'd256);
    send_item(blank_item(OP_READ, 0, 0), 1'b0);
    send_item(blank_item(OP_READ, 255, 0), 1'b0);
    send_item(blank_item(OP_READ, 255, 255), 1'b0);
    send_item(blank_item(OP_NOP, 17, 200), 1'b0);
    // collinear vertices
    send_item(tri_item(8, 8, 5000, 5000, 90000, 7000, 7000, 90000, 9000, 9000, 90000), 1'b0);
    // vertices exactly on cells, edge cells sit on the boundary
    a = 3 + GRID_COLS * 3;
    b = 6 + GRID_COLS * 3;
    c = 3 + GRID_COLS * 6;
    send_item(tri_item(5, 5, cell_lat_m[a], cell_lon_m[a], 30000,
                       cell_lat_m[b], cell_lon_m[b], 40000,
                       cell_lat_m[c], cell_lon_m[c], 50000), 1'b0);
    send_item(tri_item(12, 12, 10000, 10000, HGT_MAX, 14000, 10000, HGT_MIN,
                       10000, 14000, HGT_MAX), 1'b0);
    send_item(tri_item(10, 10, -1000, -1000, 100000, 45000, -1000, 100000,
                       -1000, 45000, 100000), 1'b0);
    send_item(blank_item(OP_READ, 10, 10), 1'b0);
    send_item(blank_item(OP_READ, 5, 4), 1'b0);
  endtask

  task automatic test_register_extremes();
    set_grid_size(9'd0, 9'd256);
    send_item(tri_item(5, 5, 0, 0, 200000, 9000, 0, 200000, 0, 9000, 200000), 1'b0);
    set_grid_size(9'd256, 9'd0);
    send_item(tri_item(5, 5, 0, 0, 200000, 9000, 0, 200000, 0, 9000, 200000), 1'b0);
    set_grid_size(9'd4, 9'd4);
    send_item(tri_item(2, 2, -900000000, -1800000000, 300000, 900000000, -1800000000, 300000,
                       -900000000, 1800000000, 300000), 1'b0);
    set_grid_size(9'd511, 9'd511);
    send_item(tri_item(250, 250, 238000, 238000, 400000, 260000, 238000, 400000,
                       238000, 260000, 400000), 1'b0);
    set_grid_size(9'd20, 9'd12);
    send_item(tri_item(250, 5, 0, 15000, 500000, 15000, 15000, 500000,
                       0, 30000, 500000), 1'b0);
    set_grid_size(9'd1, 9'd1);
    send_item(tri_item(200, 200, -500, -500, 600000, 2000, -500, 600000,
                       -500, 2000, 600000), 1'b0);
    send_item(blank_item(OP_READ, 0, 0), 1'b0);
  endtask

  task automatic run_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) begin
        if ($urandom_range(0, 1)) send_item(load_item($urandom_range(0, 31),
                                                       $urandom_range(0, 31)), 1'b0);
        else send_item(load_item($urandom_range(232, 255), $urandom_range(232, 255)), 1'b0);
      end else if (k < 58) begin
        if ($urandom_range(0, 1))
          send_item(blank_item(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31)), 1'b0);
        else
          send_item(blank_item(OP_READ, $urandom_range(232, 255),
                               $urandom_range(232, 255)), 1'b0);
      end else if (k < 60) begin
        send_item(blank_item(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255)), 1'b0);
      end else if (k < 68) begin
        send_item(noise_splat(), 1'b0);
      end else begin
        send_item(small_splat(), 1'b0);
      end
    end
  endtask

  task automatic test_random_phases();
    set_grid_size(9'd256, 9'd256);
    run_random(150);
    set_grid_size(9'd511, 9'd300);
    run_random(100);
    set_grid_size(9'd20, 9'd12);
    run_random(100);
    set_grid_size(9'd1, 9'd256);
    run_random(50);
    set_grid_size(9'd256, 9'd1);
    run_random(50);
    set_grid_size(9'd256, 9'd256);
    run_random(50);
  endtask

  task automatic test_backpressure();
    set_grid_size(9'd256, 9'd256);
    hold_request = 1500;
    for (int i = 0; i < 40; i++) begin
      if (i % 2) send_item(blank_item(OP_READ, $urandom_range(0, 31), $urandom_range(0, 31)), 1'b1);
      else send_item(load_item($urandom_range(0, 31), $urandom_range(0, 31)), 1'b1);
    end
    send_item(small_splat(), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_grid();
    test_special_cases();
    test_register_extremes();
    test_backpressure();
    test_random_phases();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
